[rtl/core/bez_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared widths, register codes, types and coordinate unpacking.
// ----------------------------------------------------------------------------
package bez_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_WIDTH     = T_FRAC_BITS + 1;
  localparam int REG_WIDTH   = 48;
  localparam int REG_COUNT   = 4;
  localparam int INDEX_WIDTH = 3;
  localparam int NUM_AXES    = 3;
  localparam int NUM_TERMS   = 4;
  localparam int SQ_WIDTH    = 2 * T_WIDTH;
  localparam int CUBE_WIDTH  = 3 * T_WIDTH;
  localparam int SHIFT       = 3 * T_FRAC_BITS;
  localparam int WGT_WIDTH   = SHIFT + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + WGT_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;

  typedef logic [T_WIDTH-1:0]     tval_t;
  typedef logic [SQ_WIDTH-1:0]    sq_t;
  typedef logic [WGT_WIDTH-1:0]   wgt_t;
  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [REG_WIDTH-1:0]   point_t;
  typedef logic [INDEX_WIDTH-1:0] reg_index_t;
  typedef logic [REG_COUNT-1:0][REG_WIDTH-1:0] points_t;
  typedef logic [PROD_WIDTH-1:0]  prod_t;
  typedef logic [SUM_WIDTH-1:0]   sum_t;

  // Bernstein weights, unsigned Q1.SHIFT
  typedef struct packed {
    wgt_t w3;
    wgt_t w2;
    wgt_t w1;
    wgt_t w0;
  } weights_t;

  localparam tval_t  T_ONE      = tval_t'(1) << T_FRAC_BITS;
  localparam coord_t COORD_SIGN = coord_t'(1) << (COORD_WIDTH - 1);
  localparam sum_t   HALF       = sum_t'(1) << (SHIFT - 1);
  localparam wgt_t   WGT_ONE    = wgt_t'(1) << SHIFT;

  // Configuration register indexes
  localparam reg_index_t REG_POINT_ZERO  = reg_index_t'(0);
  localparam reg_index_t REG_POINT_ONE   = reg_index_t'(1);
  localparam reg_index_t REG_POINT_TWO   = reg_index_t'(2);
  localparam reg_index_t REG_POINT_THREE = reg_index_t'(3);

  // Offset-binary coordinate of a packed point; bits past the register read 0
  function automatic coord_t coord_biased(point_t p, int unsigned axis);
    coord_t      c;
    int unsigned pos;
    c = '0;
    for (int unsigned k = 0; k < COORD_WIDTH; k++) begin
      pos = axis * COORD_WIDTH + k;
      c[k] = (pos < REG_WIDTH) ? p[pos[$clog2(REG_WIDTH)-1:0]] : 1'b0;
    end
    return c ^ COORD_SIGN;
  endfunction

endpackage

[rtl/core/bez_t_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parameter channel
// Valid/ready stream carrying one curve parameter per item.
// ----------------------------------------------------------------------------
interface bez_t_if;
  logic          valid;
  logic          ready;
  bez_pkg::tval_t t_value;

  modport source (output valid, output t_value, input ready);
  modport sink   (input valid, input t_value, output ready);
endinterface

[rtl/core/bez_pt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready stream carrying one curve point (x, y, z) per item.
// ----------------------------------------------------------------------------
interface bez_pt_if;
  logic           valid;
  logic           ready;
  bez_pkg::coord_t out_x;
  bez_pkg::coord_t out_y;
  bez_pkg::coord_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

[rtl/core/bez_weight.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier weight stages
// Two pipeline stages: clamp t, form t^2, u^2, t*u; then the four cubic
// Bernstein weights.
// ----------------------------------------------------------------------------
module bez_weight (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bez_pkg::tval_t    t_value,
  output logic              out_valid,
  input  logic              out_ready,
  output bez_pkg::weights_t weights
);

  // stage 1 registers
  logic           v1;
  bez_pkg::tval_t t1;
  bez_pkg::tval_t u1;
  bez_pkg::sq_t   tt1;
  bez_pkg::sq_t   uu1;
  bez_pkg::sq_t   tu1;
  // stage 2 registers
  logic              v2;
  bez_pkg::weights_t w2;

  logic           rdy1;
  logic           rdy2;
  bez_pkg::tval_t t_clamp;
  bez_pkg::tval_t u_clamp;

  logic [bez_pkg::CUBE_WIDTH-1:0] uuu;
  logic [bez_pkg::CUBE_WIDTH-1:0] tuu;
  logic [bez_pkg::CUBE_WIDTH-1:0] ttu;
  logic [bez_pkg::CUBE_WIDTH-1:0] ttt;
  logic [bez_pkg::CUBE_WIDTH+1:0] tuu3;
  logic [bez_pkg::CUBE_WIDTH+1:0] ttu3;

  // stage holds only when full and blocked downstream
  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // t above one clamps to one
  assign t_clamp = (t_value > bez_pkg::T_ONE) ? bez_pkg::T_ONE : t_value;
  assign u_clamp = bez_pkg::T_ONE - t_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      t1  <= t_clamp;
      u1  <= u_clamp;
      tt1 <= bez_pkg::SQ_WIDTH'(t_clamp) * bez_pkg::SQ_WIDTH'(t_clamp);
      uu1 <= bez_pkg::SQ_WIDTH'(u_clamp) * bez_pkg::SQ_WIDTH'(u_clamp);
      tu1 <= bez_pkg::SQ_WIDTH'(t_clamp) * bez_pkg::SQ_WIDTH'(u_clamp);
    end
  end

  // cubic terms; the middle two carry the factor 3 as shift-add
  assign uuu  = bez_pkg::CUBE_WIDTH'(uu1) * bez_pkg::CUBE_WIDTH'(u1);
  assign tuu  = bez_pkg::CUBE_WIDTH'(tu1) * bez_pkg::CUBE_WIDTH'(u1);
  assign ttu  = bez_pkg::CUBE_WIDTH'(tu1) * bez_pkg::CUBE_WIDTH'(t1);
  assign ttt  = bez_pkg::CUBE_WIDTH'(tt1) * bez_pkg::CUBE_WIDTH'(t1);
  assign tuu3 = {2'b00, tuu} + {1'b0, tuu, 1'b0};
  assign ttu3 = {2'b00, ttu} + {1'b0, ttu, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      w2.w0 <= bez_pkg::WGT_WIDTH'(uuu);
      w2.w1 <= bez_pkg::WGT_WIDTH'(tuu3);
      w2.w2 <= bez_pkg::WGT_WIDTH'(ttu3);
      w2.w3 <= bez_pkg::WGT_WIDTH'(ttt);
    end
  end

  assign out_valid = v2;
  assign weights   = w2;

  // t and u form a partition of one
  a_unit_split: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (bez_pkg::T_WIDTH'(t1 + u1) == bez_pkg::T_ONE))
    else $error("t and u do not sum to one");

  // the four weights sum to exactly one
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (bez_pkg::WGT_WIDTH'(w2.w0 + w2.w1 + w2.w2 + w2.w3) == bez_pkg::WGT_ONE))
    else $error("Bernstein weights do not sum to one");

endmodule

[rtl/core/bez_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier blend stages
// Two pipeline stages: weight each biased control coordinate, then sum,
// round to nearest and return to two's complement. Stage 4 is the output
// register.
// ----------------------------------------------------------------------------
module bez_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bez_pkg::weights_t weights,
  input  bez_pkg::points_t  points,
  output logic              out_valid,
  input  logic              out_ready,
  output bez_pkg::coord_t   out_x,
  output bez_pkg::coord_t   out_y,
  output bez_pkg::coord_t   out_z
);

  logic rdy3;
  logic rdy4;

  bez_pkg::wgt_t  w_arr  [bez_pkg::NUM_TERMS];
  bez_pkg::coord_t coord [bez_pkg::NUM_AXES][bez_pkg::NUM_TERMS];

  // stage 3: weighted terms
  logic          v3;
  bez_pkg::prod_t prod [bez_pkg::NUM_AXES][bez_pkg::NUM_TERMS];
  // stage 4: rounded point
  logic            v4;
  bez_pkg::sum_t   sum [bez_pkg::NUM_AXES];
  bez_pkg::coord_t res [bez_pkg::NUM_AXES];

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  assign w_arr[0] = weights.w0;
  assign w_arr[1] = weights.w1;
  assign w_arr[2] = weights.w2;
  assign w_arr[3] = weights.w3;

  // unpack control coordinates to offset binary
  always_comb begin
    for (int a = 0; a < bez_pkg::NUM_AXES; a++) begin
      for (int i = 0; i < bez_pkg::NUM_TERMS; i++) begin
        coord[a][i] = bez_pkg::coord_biased(points[i], a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      for (int a = 0; a < bez_pkg::NUM_AXES; a++) begin
        for (int i = 0; i < bez_pkg::NUM_TERMS; i++) begin
          prod[a][i] <= bez_pkg::PROD_WIDTH'(coord[a][i]) *
                        bez_pkg::PROD_WIDTH'(w_arr[i]);
        end
      end
    end
  end

  // exact sum plus half, then drop the fraction
  always_comb begin
    for (int a = 0; a < bez_pkg::NUM_AXES; a++) begin
      sum[a] = bez_pkg::SUM_WIDTH'(prod[a][0]) + bez_pkg::SUM_WIDTH'(prod[a][1]) +
               bez_pkg::SUM_WIDTH'(prod[a][2]) + bez_pkg::SUM_WIDTH'(prod[a][3]) +
               bez_pkg::HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int a = 0; a < bez_pkg::NUM_AXES; a++) begin
        res[a] <= sum[a][bez_pkg::SHIFT +: bez_pkg::COORD_WIDTH] ^ bez_pkg::COORD_SIGN;
      end
    end
  end

  assign out_valid = v4;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];

  // a blocked stage 3 keeps its item
  a_hold3: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy4) |=> (v3 && $stable(prod[0][0]) && $stable(prod[2][3])))
    else $error("stage 3 item lost while stalled");

  // stage 4 only fills from a valid stage 3
  a_fill4: assert property (@(posedge clk) disable iff (rst)
    (!v4 && rdy4 && !v3) |=> !v4)
    else $error("stage 4 filled without an item");

endmodule

[rtl/core/cubic_bezier_point_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator
// Evaluates a 3D cubic Bezier curve at one parameter t per item.
// ----------------------------------------------------------------------------
// Usage: write the four control points (index 0..3, signed 16-bit x, y, z
// packed in bits [15:0], [31:16], [47:32]) while the block is idle, then
// stream t values (unsigned Q1.16, values above 1.0 clamp to 1.0). Each t
// yields one point, rounded to nearest with ties toward plus infinity. The
// block is a four-stage pipeline (t products, Bernstein weights, weighted
// coordinates, sum and round) taking one item per cycle while the output is
// not stalled; each stage stalls only when it is full and the next one is
// blocked, so bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bez_pkg::reg_index_t wr_index,
  input  bez_pkg::point_t     wr_data,
  bez_t_if.sink               t_in,
  bez_pt_if.source            pt_out
);

  bez_pkg::points_t  points;
  bez_pkg::weights_t weights;
  logic              wgt_valid;
  logic              wgt_ready;

  // control point registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      points <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        bez_pkg::REG_POINT_ZERO:  points[0] <= wr_data;
        bez_pkg::REG_POINT_ONE:   points[1] <= wr_data;
        bez_pkg::REG_POINT_TWO:   points[2] <= wr_data;
        bez_pkg::REG_POINT_THREE: points[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // weight stages
  bez_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_in.valid),
    .in_ready  (t_in.ready),
    .t_value   (t_in.t_value),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .weights   (weights)
  );

  // blend stages and output register
  bez_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .weights   (weights),
    .points    (points),
    .out_valid (pt_out.valid),
    .out_ready (pt_out.ready),
    .out_x     (pt_out.out_x),
    .out_y     (pt_out.out_y),
    .out_z     (pt_out.out_z)
  );

endmodule

[verif/bez_point_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curve point checker
// Follows the register writes and predicts one point for every accepted
// t item. It compares each accepted point item, field by field, with the
// oldest prediction and counts every mismatch.
// ----------------------------------------------------------------------------
module bez_point_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bez_pkg::reg_index_t wr_index,
  input  bez_pkg::point_t     wr_data,
  bez_t_if                    t_mon,
  bez_pt_if                   pt_mon,
  output int                  mismatches,
  output int                  points_checked,
  output int                  points_pending
);
  import bez_pkg::*;

  // 16-bit coordinate times a Q1.48 weight, four terms plus the rounding half
  typedef logic [79:0] wide_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } curve_pt_t;

  // middle binomial coefficient of the cubic
  localparam wide_t BINOM_MID = wide_t'(3);

  points_t   ctrl_pts;
  curve_pt_t expected_points[$];
  int        mismatch_cnt = 0;
  int        checked_cnt  = 0;
  int        pending_cnt  = 0;

  assign mismatches     = mismatch_cnt;
  assign points_checked = checked_cnt;
  assign points_pending = pending_cnt;

  // Exact Bernstein sum on offset-binary coordinates, one rounding at the end
  function automatic curve_pt_t curve_point(points_t pts, tval_t tv);
    wide_t     tw;
    wide_t     uw;
    wide_t     acc;
    coord_t    c0;
    coord_t    c1;
    coord_t    c2;
    coord_t    c3;
    coord_t    res [NUM_AXES];
    curve_pt_t pt;
    tw = (tv > T_ONE) ? wide_t'(T_ONE) : wide_t'(tv);  // t above one clamps
    uw = wide_t'(T_ONE) - tw;
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      c0 = pts[REG_POINT_ZERO][axis*COORD_WIDTH +: COORD_WIDTH] ^ COORD_SIGN;
      c1 = pts[REG_POINT_ONE][axis*COORD_WIDTH +: COORD_WIDTH] ^ COORD_SIGN;
      c2 = pts[REG_POINT_TWO][axis*COORD_WIDTH +: COORD_WIDTH] ^ COORD_SIGN;
      c3 = pts[REG_POINT_THREE][axis*COORD_WIDTH +: COORD_WIDTH] ^ COORD_SIGN;
      acc = wide_t'(c0) * uw * uw * uw
          + BINOM_MID * wide_t'(c1) * tw * uw * uw
          + BINOM_MID * wide_t'(c2) * tw * tw * uw
          + wide_t'(c3) * tw * tw * tw
          + (wide_t'(1) << (SHIFT - 1));               // ties go up
      res[axis] = coord_t'(acc >> SHIFT) ^ COORD_SIGN;
    end
    pt.x = res[0];
    pt.y = res[1];
    pt.z = res[2];
    return pt;
  endfunction

  task automatic flag_mismatch(input string what, input coord_t seen, input coord_t want);
    $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what,
             $signed(seen), $signed(want));
    mismatch_cnt++;
  endtask

  // Register shadow, prediction on t items, comparison on point items
  always @(posedge clk) begin : watch
    curve_pt_t got;
    curve_pt_t want;
    if (rst) begin
      ctrl_pts <= '0;
      expected_points.delete();
      pending_cnt = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_POINT_ZERO, REG_POINT_ONE, REG_POINT_TWO, REG_POINT_THREE: begin
            ctrl_pts[wr_index] <= wr_data;
          end
          default: ;  // unknown index: ignored
        endcase
      end
      if (pt_mon.valid && pt_mon.ready) begin
        got.x = pt_mon.out_x;
        got.y = pt_mon.out_y;
        got.z = pt_mon.out_z;
        if (expected_points.size() == 0) begin
          flag_mismatch("point item with no t pending, x", got.x, '0);
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x) flag_mismatch("out_x", got.x, want.x);
          if (got.y !== want.y) flag_mismatch("out_y", got.y, want.y);
          if (got.z !== want.z) flag_mismatch("out_z", got.z, want.z);
          checked_cnt++;
        end
      end
      // new prediction goes to the tail of the queue
      if (t_mon.valid && t_mon.ready) begin
        expected_points = {expected_points, curve_point(ctrl_pts, t_mon.t_value)};
      end
      pending_cnt = expected_points.size();
    end
  end

endmodule

[verif/tb_cubic_bezier_point_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator testbench
// Loads control points through the write port and streams t items with
// random source gaps and sink stalls. A directed set covers t at zero, one,
// above one, coordinate extremes and rounding ties; random phases follow.
// The checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_point_eval;
  import bez_pkg::*;

  localparam int PIPE_LATENCY = 4;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 200;
  localparam int INDEX_MAX    = (1 << INDEX_WIDTH) - 1;

  logic       clk;
  logic       rst;
  logic       wr_en;
  reg_index_t wr_index;
  point_t     wr_data;

  bit src_gaps;
  bit sink_stalls;
  int t_sent;
  int settings_used;
  int mismatches;
  int points_checked;
  int points_pending;

  bez_t_if  t_ch ();
  bez_pt_if pt_ch ();

  cubic_bezier_point_eval u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .t_in     (t_ch),
    .pt_out   (pt_ch)
  );

  bez_point_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .t_mon          (t_ch),
    .pt_mon         (pt_ch),
    .mismatches     (mismatches),
    .points_checked (points_checked),
    .points_pending (points_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d points still pending", points_pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Point sink: random stall bursts while enabled
  initial begin : sink_side
    int stall;
    pt_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 9) == 0) begin
        pt_ch.ready = 1'b0;
        stall = $urandom_range(1, 19);
        repeat (stall) @(negedge clk);
      end
      pt_ch.ready = 1'b1;
    end
  end

  task automatic write_reg(input reg_index_t idx, input point_t value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(posedge clk);
  endtask

  task automatic close_writes();
    @(negedge clk);
    wr_en = 1'b0;
    settings_used++;
  endtask

  // One t item, with an optional gap in front; valid stays up after the item
  task automatic send_t(input tval_t tv);
    int gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      t_ch.valid = 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    t_ch.valid   = 1'b1;
    t_ch.t_value = tv;
    do @(posedge clk); while (!t_ch.ready);
    t_sent++;
  endtask

  // Stop sending and wait until every predicted point has come out
  task automatic drain();
    @(negedge clk);
    t_ch.valid = 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (2 * PIPE_LATENCY) @(negedge clk);
  endtask

  function automatic point_t pack_pt(input coord_t x, input coord_t y, input coord_t z);
    return {z, y, x};
  endfunction

  // Coordinates lean toward the extremes of the signed range
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_SIGN;
      1:       return ~COORD_SIGN;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    return pack_pt(rand_coord(), rand_coord(), rand_coord());
  endfunction

  // Mostly t in [0, 1], some edges, some clamped values above one
  function automatic tval_t rand_t();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return tval_t'(1);
          2:       return T_ONE - tval_t'(1);
          default: return T_ONE;
        endcase
      end
      1:       return tval_t'($urandom_range(0, (1 << T_WIDTH) - 1));
      default: return tval_t'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  initial begin : stimulus
    tval_t edge_ts [11];
    wr_en        = 1'b0;
    wr_index     = REG_POINT_ZERO;
    wr_data      = '0;
    t_ch.valid   = 1'b0;
    t_ch.t_value = '0;
    src_gaps     = 1'b1;
    sink_stalls  = 1'b1;
    t_sent        = 0;
    settings_used = 0;
    rst          = 1'b1;
    edge_ts = '{tval_t'(0), tval_t'(1), T_ONE - tval_t'(1), T_ONE, T_ONE + tval_t'(1),
                '1, tval_t'(32768), tval_t'(17'h0AAAA), tval_t'(17'h15555),
                tval_t'(16384), tval_t'(49152)};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // control points straight out of reset
    send_t('0);
    send_t(T_ONE);
    drain();

    // coordinate extremes, plus two writes to unknown indexes that must not land
    write_reg(REG_POINT_ZERO,  pack_pt(16'h8000, 16'h8000, 16'h8000));
    write_reg(REG_POINT_ONE,   pack_pt(16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(REG_POINT_TWO,   pack_pt(16'hFFFF, 16'h0000, 16'h8000));
    write_reg(REG_POINT_THREE, pack_pt(16'h7FFF, 16'h8000, 16'h0001));
    write_reg(reg_index_t'(INDEX_MAX), '1);
    write_reg(reg_index_t'(int'(REG_POINT_THREE) + 1), '1);
    close_writes();
    foreach (edge_ts[i]) send_t(edge_ts[i]);
    drain();

    // exact halves at t = 1/2: x and y tie upward, z ties from below to zero
    write_reg(REG_POINT_ZERO,  pack_pt(16'h8004, 16'h0004, 16'hFFFC));
    write_reg(REG_POINT_ONE,   pack_pt(16'h8000, 16'h0000, 16'h0000));
    write_reg(REG_POINT_TWO,   pack_pt(16'h8000, 16'h0000, 16'h0000));
    write_reg(REG_POINT_THREE, pack_pt(16'h8000, 16'h0000, 16'h0000));
    close_writes();
    send_t(tval_t'(32768));
    send_t('0);
    send_t(T_ONE);
    drain();

    // all points at the top, then all at the bottom of the range
    for (int r = 0; r < REG_COUNT; r++) write_reg(reg_index_t'(r), {NUM_AXES{~COORD_SIGN}});
    close_writes();
    send_t(tval_t'(21845));
    send_t(T_ONE - tval_t'(1));
    drain();
    for (int r = 0; r < REG_COUNT; r++) write_reg(reg_index_t'(r), {NUM_AXES{COORD_SIGN}});
    close_writes();
    send_t(tval_t'(43691));
    send_t(tval_t'(1));
    drain();

    // random phases; one middle phase and the last one run without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      src_gaps    = (ph != 3) && (ph != PHASES - 1);
      sink_stalls = src_gaps;
      for (int r = 0; r < REG_COUNT; r++) write_reg(reg_index_t'(r), rand_point());
      if (ph % 2 == 1) begin
        write_reg(reg_index_t'($urandom_range(int'(REG_POINT_THREE) + 1, INDEX_MAX)),
                  rand_point());
      end
      close_writes();
      repeat (PHASE_ITEMS) send_t(rand_t());
      drain();
    end

    $display("Ran %0d t items across %0d control-point settings; %0d points compared.",
             t_sent, settings_used, points_checked);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
